// ----- src/atp_pkg.sv -----
// Shared types, constants and the atan lookup function for the arc tessellator.
package atp_pkg;

	localparam int ANG_W        = 32;
	localparam int XW           = 36;
	localparam int ZW           = 30;
	localparam int DIV_W        = 30;
	localparam int SQ_W         = 62;
	localparam int STEPS_W      = 7;
	localparam int CORDIC_STEPS = 27;
	localparam int MAX_POINTS   = 72;
	localparam int SQRT_STEPS   = 31;

	localparam logic signed [ANG_W-1:0] ANG_ONE     = ANG_W'(1048576);
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 * 1048576);
	localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(180 * 1048576);
	localparam logic signed [ANG_W-1:0] ANG_3Q      = ANG_W'(270 * 1048576);
	localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(360 * 1048576);
	localparam logic signed [XW-1:0]    GAIN_INV    = XW'(652032874);

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ANG0_GO,
		OP_ANG0_SAVE_GO,
		OP_ANG1_SAVE,
		OP_UNWRAP,
		OP_COUNT_GO,
		OP_DIV_GO,
		OP_DIV_FIN,
		OP_PT_ACC,
		OP_FOLD,
		OP_COS_GO,
		OP_COS_SAVE,
		OP_MUL,
		OP_SUM,
		OP_XDIV,
		OP_DX,
		OP_SQ,
		OP_SQRT_GO,
		OP_PT_FIN,
		OP_END
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic cnt_done;
		logic div_done;
		logic sqrt_done;
		logic more_inner;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic [31:0] center_x;
		logic [31:0] center_y;
		logic [31:0] start_x;
		logic [31:0] start_y;
		logic [31:0] end_x;
		logic [31:0] end_y;
		logic [30:0] radius;
		logic        counter_clockwise;
	} arc_t;

	typedef struct packed {
		logic [31:0] first_x;
		logic [31:0] first_y;
		logic [31:0] second_x;
		logic [31:0] second_y;
		logic        second_valid;
		logic        last_of_arc;
	} res_t;

	// atan(2^-i) in Q.20 degrees, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(47185920);
			5'd1:    v = ZW'(27855475);
			5'd2:    v = ZW'(14718068);
			5'd3:    v = ZW'(7471121);
			5'd4:    v = ZW'(3750058);
			5'd5:    v = ZW'(1876857);
			5'd6:    v = ZW'(938658);
			5'd7:    v = ZW'(469357);
			5'd8:    v = ZW'(234682);
			5'd9:    v = ZW'(117342);
			5'd10:   v = ZW'(58671);
			5'd11:   v = ZW'(29335);
			5'd12:   v = ZW'(14668);
			5'd13:   v = ZW'(7334);
			5'd14:   v = ZW'(3667);
			5'd15:   v = ZW'(1833);
			5'd16:   v = ZW'(917);
			5'd17:   v = ZW'(458);
			5'd18:   v = ZW'(229);
			5'd19:   v = ZW'(115);
			5'd20:   v = ZW'(57);
			5'd21:   v = ZW'(29);
			5'd22:   v = ZW'(14);
			5'd23:   v = ZW'(7);
			5'd24:   v = ZW'(4);
			5'd25:   v = ZW'(2);
			5'd26:   v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/atp_arc_if.sv -----
// Arc input channel: valid/ready handshake with the arc description.
interface atp_arc_if;
	logic        valid;
	logic        ready;
	logic [31:0] center_x;
	logic [31:0] center_y;
	logic [31:0] start_x;
	logic [31:0] start_y;
	logic [31:0] end_x;
	logic [31:0] end_y;
	logic [30:0] radius;
	logic        counter_clockwise;

	modport source (
		output valid, center_x, center_y, start_x, start_y, end_x, end_y, radius,
		counter_clockwise,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, start_x, start_y, end_x, end_y, radius,
		counter_clockwise,
		output ready
	);
endinterface

// ----- src/atp_pts_if.sv -----
// Point output channel: valid/ready handshake with two polyline points per item.
interface atp_pts_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_x;
	logic [31:0] first_y;
	logic [31:0] second_x;
	logic [31:0] second_y;
	logic        second_valid;
	logic        last_of_arc;

	modport source (
		output valid, first_x, first_y, second_x, second_y, second_valid, last_of_arc,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, second_x, second_y, second_valid, last_of_arc,
		output ready
	);
endinterface

// ----- src/atp_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module atp_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          vect,
	input  logic signed [atp_pkg::XW-1:0] x0,
	input  logic signed [atp_pkg::XW-1:0] y0,
	input  logic signed [atp_pkg::ZW-1:0] z0,
	output logic                          done,
	output logic signed [atp_pkg::XW-1:0] x,
	output logic signed [atp_pkg::ZW-1:0] z
);
	import atp_pkg::*;

	logic signed [XW-1:0] x_q, y_q, x_n, y_n, sx, sy;
	logic signed [ZW-1:0] z_q, z_n, at;
	logic [4:0]           i_q;
	logic                 run_q, done_q, vect_q;

	always_comb begin
		sx  = x_q >>> i_q;
		sy  = y_q >>> i_q;
		at  = atan_q20(i_q);
		x_n = x_q;
		y_n = y_q;
		z_n = z_q;
		if (vect_q) begin
			if (y_q > 0) begin
				x_n = x_q + sy;
				y_n = y_q - sx;
				z_n = z_q + at;
			end else if (y_q < 0) begin
				x_n = x_q - sy;
				y_n = y_q + sx;
				z_n = z_q - at;
			end
		end else if (z_q >= 0) begin
			x_n = x_q - sy;
			y_n = y_q + sx;
			z_n = z_q - at;
		end else begin
			x_n = x_q + sy;
			y_n = y_q - sx;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && i_q == 5'(CORDIC_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			i_q    <= '0;
			vect_q <= vect;
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			i_q <= i_q + 5'd1;
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign z    = z_q;
endmodule

// ----- src/atp_isqrt.sv -----
// Bit-pair integer square root, one result bit per cycle.
module atp_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [atp_pkg::SQ_W-1:0]    n0,
	output logic                        done,
	output logic [atp_pkg::SQ_W/2-1:0]  root
);
	import atp_pkg::*;

	logic [SQ_W-1:0] n_q, res_q, bit_q, trial;
	logic [4:0]      cnt_q;
	logic            run_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == 5'(SQRT_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n0;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
			cnt_q <= '0;
		end else if (run_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_W/2-1:0];
endmodule

// ----- src/atp_dp.sv -----
// Datapath: angle, step count, step division, point math and result packing.
module atp_dp #(
	parameter int STEP_DEGREES = 5,
	parameter int COORD_BITS   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  atp_pkg::arc_t  arc_in,
	input  atp_pkg::cmd_t  cmd,
	output atp_pkg::stat_t st,
	output atp_pkg::res_t  res,
	output logic           res_valid,
	input  logic           res_ready
);
	import atp_pkg::*;

	localparam logic [DIV_W-1:0] STEP_Q = DIV_W'(STEP_DEGREES * 1048576);
	localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (COORD_BITS - 1)) - 36'sd1;
	localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

	function automatic logic signed [32:0] sext(input logic [31:0] v);
		return {{(33 - COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]};
	endfunction

	function automatic logic [31:0] sat(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = v;
		if (v > SAT_HI)
			r = SAT_HI;
		else if (v < SAT_LO)
			r = SAT_LO;
		return r[31:0];
	endfunction

	function automatic logic signed [ANG_W-1:0] ang_of(
		input logic signed [33:0]   dx,
		input logic signed [33:0]   dy,
		input logic signed [ZW-1:0] zr
	);
		logic signed [ANG_W-1:0] zc, a;
		zc = ANG_W'(zr);
		if (zc < $signed(ANG_W'(1)))
			zc = $signed(ANG_W'(1));
		if (zc > ANG_QUARTER - $signed(ANG_W'(1)))
			zc = ANG_QUARTER - $signed(ANG_W'(1));
		if (dy == 0)
			a = (dx > 0) ? '0 : ANG_HALF;
		else if (dx == 0)
			a = (dy > 0) ? ANG_QUARTER : ANG_3Q;
		else if (dx > 0)
			a = (dy > 0) ? zc : ANG_FULL - zc;
		else
			a = (dy > 0) ? ANG_HALF - zc : ANG_HALF + zc;
		return a;
	endfunction

	// arc registers
	logic signed [32:0] cx_q, cy_q, sx_q, sy_q, ex_q, ey_q;
	logic [30:0]        r_q;
	logic               ccw_q;

	logic signed [33:0] sdx, sdy, edx, edy;
	logic signed [ANG_W-1:0] a0_q, a1_q, sweep_q, step_q, acc_q;
	logic [DIV_W-1:0]   mag_q, rem_q, dq_q;
	logic [SQ_W-1:0]    r2_q, sq_q;
	logic [STEPS_W-1:0] steps_q, j_q;
	logic               cnt_run_q, cnt_done_q, div_run_q, div_done_q;
	logic [6:0]         drem_q;
	logic [4:0]         dcnt_q;
	logic [7:0]         trial;
	logic               trial_ge;

	logic signed [ZW-1:0]  b_q;
	logic                  cneg_q, sneg_q;
	logic signed [31:0]    c_q;
	logic signed [63:0]    prod_q;
	logic signed [64:0]    sum_q;
	logic signed [34:0]    x_q;
	logic [30:0]           dxa_q;
	logic                  dy_zero_q;

	logic                  slot_full_q, out_valid_q;
	logic [31:0]           hold_x_q, hold_y_q;
	res_t                  res_q;

	// unit hookup
	logic                  cor_start, cor_vect, cor_done;
	logic signed [XW-1:0]  cor_x0, cor_y0, cor_x;
	logic signed [ZW-1:0]  cor_z0, cor_z;
	logic                  sq_start, sq_done;
	logic [SQ_W/2-1:0]     root;

	// combinational helpers
	logic signed [ANG_W-1:0] a0n, a1n, sw, mag, am, bfold, quo;
	logic                    cneg_n;
	logic signed [31:0]      cv;
	logic signed [34:0]      xfl;
	logic signed [35:0]      dd, ad, yv;
	logic [31:0]             xs, ys;

	assign sdx = 34'(sx_q) - 34'(cx_q);
	assign sdy = 34'(sy_q) - 34'(cy_q);
	assign edx = 34'(ex_q) - 34'(cx_q);
	assign edy = 34'(ey_q) - 34'(cy_q);

	always_comb begin
		cor_start = 1'b0;
		cor_vect  = 1'b1;
		cor_x0    = GAIN_INV;
		cor_y0    = '0;
		cor_z0    = '0;
		case (cmd.op)
			OP_ANG0_GO: begin
				cor_start = 1'b1;
				cor_x0    = XW'((sdx < 0) ? -sdx : sdx);
				cor_y0    = XW'((sdy < 0) ? -sdy : sdy);
			end
			OP_ANG0_SAVE_GO: begin
				cor_start = 1'b1;
				cor_x0    = XW'((edx < 0) ? -edx : edx);
				cor_y0    = XW'((edy < 0) ? -edy : edy);
			end
			OP_COS_GO: begin
				cor_start = 1'b1;
				cor_vect  = 1'b0;
				cor_z0    = b_q;
			end
			default: begin
			end
		endcase
	end

	assign sq_start = (cmd.op == OP_SQRT_GO);

	atp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.vect   (cor_vect),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.z0     (cor_z0),
		.done   (cor_done),
		.x      (cor_x),
		.z      (cor_z)
	);

	atp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n0     (r2_q - sq_q),
		.done   (sq_done),
		.root   (root)
	);

	always_comb begin
		// unwrap one angle so the sweep follows the direction
		a0n = a0_q;
		a1n = a1_q;
		if (ccw_q) begin
			if (a0_q > a1_q)
				a1n = a1_q + ANG_FULL;
		end else if (a0_q <= a1_q) begin
			a0n = a0_q + ANG_FULL;
		end
		sw  = a1n - a0n;
		mag = (sw < 0) ? -sw : sw;

		trial    = {drem_q, dq_q[DIV_W-1]};
		trial_ge = trial >= {1'b0, steps_q};
		quo      = ANG_W'(dq_q);

		// wrap into one turn and fold onto the first quadrant
		am = acc_q;
		if (acc_q >= ANG_FULL)
			am = acc_q - ANG_FULL;
		else if (acc_q < 0)
			am = acc_q + ANG_FULL;
		if (am <= ANG_QUARTER) begin
			bfold = am;
			cneg_n = 1'b0;
		end else if (am <= ANG_HALF) begin
			bfold = ANG_HALF - am;
			cneg_n = 1'b1;
		end else if (am <= ANG_3Q) begin
			bfold = am - ANG_HALF;
			cneg_n = 1'b1;
		end else begin
			bfold = ANG_FULL - am;
			cneg_n = 1'b0;
		end

		cv  = 32'(cor_x);
		xfl = 35'(sum_q >>> 30);
		if (sum_q[64] && (sum_q[29:0] != '0))
			xfl = xfl + 35'sd1;
		dd = 36'(x_q) - 36'(cx_q);
		ad = (dd < 0) ? -dd : dd;
		yv = sneg_q ? 36'(cy_q) - $signed({5'b0, dy_zero_q ? 31'd0 : root})
		            : 36'(cy_q) + $signed({5'b0, dy_zero_q ? 31'd0 : root});
		xs = sat(36'(x_q));
		ys = sat(yv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_run_q   <= 1'b0;
			cnt_done_q  <= 1'b0;
			div_run_q   <= 1'b0;
			div_done_q  <= 1'b0;
			slot_full_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_done_q <= 1'b0;
			div_done_q <= 1'b0;
			if (out_valid_q && res_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_COUNT_GO: cnt_run_q <= 1'b1;
				OP_DIV_GO:   div_run_q <= 1'b1;
				OP_DIV_FIN:  slot_full_q <= 1'b0;
				OP_PT_FIN: begin
					slot_full_q <= !slot_full_q;
					if (slot_full_q)
						out_valid_q <= 1'b1;
				end
				OP_END: begin
					slot_full_q <= 1'b0;
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
			if (cnt_run_q && !(rem_q >= STEP_Q && steps_q < STEPS_W'(MAX_POINTS))) begin
				cnt_run_q  <= 1'b0;
				cnt_done_q <= 1'b1;
			end
			if (div_run_q && dcnt_q == 5'(DIV_W - 1)) begin
				div_run_q  <= 1'b0;
				div_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q  <= sext(arc_in.center_x);
			cy_q  <= sext(arc_in.center_y);
			sx_q  <= sext(arc_in.start_x);
			sy_q  <= sext(arc_in.start_y);
			ex_q  <= sext(arc_in.end_x);
			ey_q  <= sext(arc_in.end_y);
			r_q   <= arc_in.radius;
			ccw_q <= arc_in.counter_clockwise;
		end
		if (cnt_run_q && rem_q >= STEP_Q && steps_q < STEPS_W'(MAX_POINTS)) begin
			rem_q   <= rem_q - STEP_Q;
			steps_q <= steps_q + STEPS_W'(1);
		end
		if (div_run_q) begin
			drem_q <= trial_ge ? 7'(trial - {1'b0, steps_q}) : trial[6:0];
			dq_q   <= {dq_q[DIV_W-2:0], trial_ge};
			dcnt_q <= dcnt_q + 5'd1;
		end
		case (cmd.op)
			OP_ANG0_SAVE_GO: a0_q <= ang_of(sdx, sdy, cor_z);
			OP_ANG1_SAVE:    a1_q <= ang_of(edx, edy, cor_z);
			OP_UNWRAP: begin
				a0_q    <= a0n;
				sweep_q <= sw;
				mag_q   <= mag[DIV_W-1:0];
				r2_q    <= SQ_W'(r_q) * SQ_W'(r_q);
			end
			OP_COUNT_GO: begin
				rem_q   <= mag_q;
				steps_q <= STEPS_W'(1);
			end
			OP_DIV_GO: begin
				dq_q   <= mag_q;
				drem_q <= '0;
				dcnt_q <= '0;
			end
			OP_DIV_FIN: begin
				step_q <= (sweep_q < 0) ? -quo : quo;
				acc_q  <= a0_q;
				j_q    <= '0;
			end
			OP_PT_ACC: acc_q <= acc_q + step_q;
			OP_FOLD: begin
				b_q    <= ZW'(bfold);
				cneg_q <= cneg_n;
				sneg_q <= am > ANG_HALF;
			end
			OP_COS_SAVE: c_q <= cneg_q ? -cv : cv;
			OP_MUL:      prod_q <= 64'($signed({1'b0, r_q})) * 64'(c_q);
			OP_SUM:      sum_q <= (65'(cx_q) <<< 30) + 65'(prod_q);
			OP_XDIV:     x_q <= xfl;
			OP_DX: begin
				dxa_q     <= ad[30:0];
				dy_zero_q <= ad >= $signed({5'b0, r_q});
			end
			OP_SQ: sq_q <= SQ_W'(dxa_q) * SQ_W'(dxa_q);
			OP_PT_FIN: begin
				j_q <= j_q + STEPS_W'(1);
				if (slot_full_q) begin
					res_q <= '{first_x: hold_x_q, first_y: hold_y_q, second_x: xs,
						second_y: ys, second_valid: 1'b1, last_of_arc: 1'b0};
				end else begin
					hold_x_q <= xs;
					hold_y_q <= ys;
				end
			end
			OP_END: begin
				if (slot_full_q)
					res_q <= '{first_x: hold_x_q, first_y: hold_y_q, second_x: ex_q[31:0],
						second_y: ey_q[31:0], second_valid: 1'b1, last_of_arc: 1'b1};
				else
					res_q <= '{first_x: ex_q[31:0], first_y: ey_q[31:0], second_x: '0,
						second_y: '0, second_valid: 1'b0, last_of_arc: 1'b1};
			end
			default: begin
			end
		endcase
	end

	assign st.cordic_done = cor_done;
	assign st.cnt_done    = cnt_done_q;
	assign st.div_done    = div_done_q;
	assign st.sqrt_done   = sq_done;
	assign st.more_inner  = ({1'b0, j_q} + (STEPS_W + 1)'(1)) < {1'b0, steps_q};
	assign st.out_busy    = out_valid_q;
	assign res            = res_q;
	assign res_valid      = out_valid_q;
endmodule

// ----- src/atp_ctrl.sv -----
// Controller: sequences the datapath through angles, step setup and points.
module atp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           arc_valid,
	output logic           arc_ready,
	input  atp_pkg::stat_t st,
	output atp_pkg::cmd_t  cmd
);
	import atp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_ANG0, S_ANG1, S_UNWRAP, S_CNT_GO, S_COUNT, S_DIV, S_SETTLE,
		S_PT_CHK, S_FOLD, S_COS_GO, S_COS, S_MUL, S_SUM, S_XDIV, S_DX, S_SQ,
		S_SQRT_GO, S_SQRT, S_FIN_WAIT, S_END_WAIT, S_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ready_q  <= 1'b1;
			cmd_q.op <= OP_NONE;
		end else begin
			cmd_q.op <= OP_NONE;
			case (state_q)
				S_IDLE: begin
					if (arc_valid && ready_q) begin
						ready_q  <= 1'b0;
						cmd_q.op <= OP_ANG0_GO;
						state_q  <= S_ANG0;
					end
				end
				S_ANG0: begin
					if (st.cordic_done) begin
						cmd_q.op <= OP_ANG0_SAVE_GO;
						state_q  <= S_ANG1;
					end
				end
				S_ANG1: begin
					if (st.cordic_done) begin
						cmd_q.op <= OP_ANG1_SAVE;
						state_q  <= S_UNWRAP;
					end
				end
				S_UNWRAP: begin
					cmd_q.op <= OP_UNWRAP;
					state_q  <= S_CNT_GO;
				end
				S_CNT_GO: begin
					cmd_q.op <= OP_COUNT_GO;
					state_q  <= S_COUNT;
				end
				S_COUNT: begin
					if (st.cnt_done) begin
						cmd_q.op <= OP_DIV_GO;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (st.div_done) begin
						cmd_q.op <= OP_DIV_FIN;
						state_q  <= S_SETTLE;
					end
				end
				S_SETTLE: state_q <= S_PT_CHK;
				S_PT_CHK: begin
					if (st.more_inner) begin
						cmd_q.op <= OP_PT_ACC;
						state_q  <= S_FOLD;
					end else begin
						state_q <= S_END_WAIT;
					end
				end
				S_FOLD: begin
					cmd_q.op <= OP_FOLD;
					state_q  <= S_COS_GO;
				end
				S_COS_GO: begin
					cmd_q.op <= OP_COS_GO;
					state_q  <= S_COS;
				end
				S_COS: begin
					if (st.cordic_done) begin
						cmd_q.op <= OP_COS_SAVE;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					cmd_q.op <= OP_MUL;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					cmd_q.op <= OP_SUM;
					state_q  <= S_XDIV;
				end
				S_XDIV: begin
					cmd_q.op <= OP_XDIV;
					state_q  <= S_DX;
				end
				S_DX: begin
					cmd_q.op <= OP_DX;
					state_q  <= S_SQ;
				end
				S_SQ: begin
					cmd_q.op <= OP_SQ;
					state_q  <= S_SQRT_GO;
				end
				S_SQRT_GO: begin
					cmd_q.op <= OP_SQRT_GO;
					state_q  <= S_SQRT;
				end
				S_SQRT: begin
					if (st.sqrt_done)
						state_q <= S_FIN_WAIT;
				end
				S_FIN_WAIT: begin
					if (!st.out_busy) begin
						cmd_q.op <= OP_PT_FIN;
						state_q  <= S_SETTLE;
					end
				end
				S_END_WAIT: begin
					if (!st.out_busy) begin
						cmd_q.op <= OP_END;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign arc_ready = ready_q;
	assign cmd       = cmd_q;
endmodule

// ----- src/arc_to_polyline_tessellator_unit.sv -----
// Top level of the arc to polyline tessellator: controller plus datapath.
//
//  channel  | dir | handshake     | item
//  ---------+-----+---------------+---------------------------------------------
//  arc      | in  | valid / ready | center, start, end, radius, direction
//  points   | out | valid / ready | up to two polyline points, last-of-arc flag
//
// One arc is worked at a time. Setup runs two CORDIC angle passes, the step
// counting and a divide. Each inner point then runs the 27-step cos CORDIC
// and the 31-step square root; an arc yields at most 72 points.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled points channel holds its item; the next point waits on it.
module arc_to_polyline_tessellator_unit #(
	parameter int STEP_DEGREES = 5,
	parameter int COORD_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	atp_arc_if.sink     arc,
	atp_pts_if.source   points
);
	import atp_pkg::*;

	arc_t  arc_item;
	res_t  res;
	cmd_t  cmd;
	stat_t st;
	logic  res_valid;
	logic  load;

	// pack the incoming arc item
	assign arc_item = '{center_x: arc.center_x, center_y: arc.center_y,
		start_x: arc.start_x, start_y: arc.start_y, end_x: arc.end_x, end_y: arc.end_y,
		radius: arc.radius, counter_clockwise: arc.counter_clockwise};

	// capture the arc on the accepting edge
	assign load = arc.valid && arc.ready;

	atp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.arc_valid (arc.valid),
		.arc_ready (arc.ready),
		.st        (st),
		.cmd       (cmd)
	);

	atp_dp #(
		.STEP_DEGREES (STEP_DEGREES),
		.COORD_BITS   (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.arc_in    (arc_item),
		.cmd       (cmd),
		.st        (st),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (points.ready)
	);

	// drive the points channel straight from the result register
	assign points.valid        = res_valid;
	assign points.first_x      = res.first_x;
	assign points.first_y      = res.first_y;
	assign points.second_x     = res.second_x;
	assign points.second_y     = res.second_y;
	assign points.second_valid = res.second_valid;
	assign points.last_of_arc  = res.last_of_arc;
endmodule

// ----- src/atp_checker.sv -----
// Port-level checks for the tessellator, bound to the top level.
module atp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        arc_valid,
	input logic        arc_ready,
	input logic        pts_valid,
	input logic        pts_ready,
	input logic [31:0] second_x,
	input logic [31:0] second_y,
	input logic        second_valid,
	input logic        last_of_arc
);
	// a stalled result item stays offered
	a_pts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && !pts_ready |=> pts_valid)
		else $error("result item dropped while stalled");

	// one arc at a time: no second arc right after an accept
	a_one_arc: assert property (@(posedge clk) disable iff (!arst_n)
		arc_valid && arc_ready |=> !arc_ready)
		else $error("arc accepted while another is in work");

	// only the final item of an arc may carry a single point
	a_half_last: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && !second_valid |-> last_of_arc)
		else $error("half-filled item before the end of the arc");

	// an empty second slot reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && !second_valid |-> second_x == 32'd0 && second_y == 32'd0)
		else $error("empty second slot holds data");
endmodule

bind arc_to_polyline_tessellator_unit atp_checker u_atp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.arc_valid    (arc.valid),
	.arc_ready    (arc.ready),
	.pts_valid    (points.valid),
	.pts_ready    (points.ready),
	.second_x     (points.second_x),
	.second_y     (points.second_y),
	.second_valid (points.second_valid),
	.last_of_arc  (points.last_of_arc)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the arc to polyline tessellator.
`timescale 1ns / 1ps

module testbench;
	import atp_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam longint Q20_ONE  = 1048576;
	localparam longint Q20_HALF = 180 * Q20_ONE;
	localparam longint Q20_QTR  = 90 * Q20_ONE;
	localparam longint Q20_FULL = 360 * Q20_ONE;
	localparam longint COS_UNIT = 1073741824;
	localparam int     STEP_DEG = 5;
	localparam int     POINT_CAP = 72;

	logic clk;
	logic arst_n;

	atp_arc_if arc_ch();
	atp_pts_if pts_ch();

	arc_to_polyline_tessellator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.arc    (arc_ch),
		.points (pts_ch)
	);

	// arctangent steps in Q.20 degrees
	const longint atan_step[27] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
		469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
		458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	res_t   pending_points[$];
	int     mismatches;
	int     arcs_sent;
	int     results_seen;
	int     idle_cycles;
	bit     steady;       // hold valid/ready high, no idling
	bit     wrapped_up;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Direction from the centre to a point, Q.20 degrees over [0,360).
	function automatic longint heading(longint ox, longint oy, longint px, longint py);
		longint dx, dy, x, y, z, t;
		dx = px - ox;
		dy = py - oy;
		z = 0;
		if (dy == 0) return (dx > 0) ? 0 : Q20_HALF;
		if (dx == 0) return (dy > 0) ? Q20_QTR : 3 * Q20_QTR;
		x = (dx < 0) ? -dx : dx;
		y = (dy < 0) ? -dy : dy;
		for (int i = 0; i < 27; i++) begin
			t = x;
			if (y > 0) begin
				x += y >>> i; y -= t >>> i; z += atan_step[i];
			end else if (y < 0) begin
				x -= y >>> i; y += t >>> i; z -= atan_step[i];
			end
		end
		if (z < 1) z = 1;
		if (z > Q20_QTR - 1) z = Q20_QTR - 1;
		if (dx > 0) return (dy > 0) ? z : Q20_FULL - z;
		return (dy > 0) ? Q20_HALF - z : Q20_HALF + z;
	endfunction

	// Cosine of a first-quadrant angle, Q.30.
	function automatic longint quadrant_cos(longint b);
		longint x, y, z, t;
		x = 652032874; y = 0; z = b;
		for (int i = 0; i < 27; i++) begin
			t = x;
			if (z >= 0) begin
				x -= y >>> i; y += t >>> i; z -= atan_step[i];
			end else begin
				x += y >>> i; y -= t >>> i; z += atan_step[i];
			end
		end
		return x;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Tessellate one arc and queue the point pairs it should produce.
	task automatic queue_polyline(arc_t a);
		longint cx, cy, r, a0, a1, sweep, mag, steps, step_ang, ang, b, c, x, dx, dy;
		logic [31:0] px[$], py[$];
		bit cneg, sneg;
		res_t item;
		int n;
		cx = longint'(signed'(a.center_x));
		cy = longint'(signed'(a.center_y));
		r  = longint'(a.radius);
		a0 = heading(cx, cy, longint'(signed'(a.start_x)), longint'(signed'(a.start_y)));
		a1 = heading(cx, cy, longint'(signed'(a.end_x)), longint'(signed'(a.end_y)));
		if (a.counter_clockwise) begin
			if (a0 > a1) a1 += Q20_FULL;
		end else begin
			if (a0 <= a1) a0 += Q20_FULL;
		end
		sweep = a1 - a0;
		mag = (sweep < 0) ? -sweep : sweep;
		steps = mag / (STEP_DEG * Q20_ONE) + 1;
		if (steps > POINT_CAP) steps = POINT_CAP;
		step_ang = sweep / steps;
		for (longint j = 1; j < steps; j++) begin
			ang = (a0 + j * step_ang) % Q20_FULL;
			if (ang < 0) ang += Q20_FULL;
			// sine exactly zero counts as non-negative
			sneg = ang > Q20_HALF;
			if (ang <= Q20_QTR) begin
				b = ang; cneg = 0;
			end else if (ang <= Q20_HALF) begin
				b = Q20_HALF - ang; cneg = 1;
			end else if (ang <= 3 * Q20_QTR) begin
				b = ang - Q20_HALF; cneg = 1;
			end else begin
				b = Q20_FULL - ang; cneg = 0;
			end
			c = quadrant_cos(b);
			if (cneg) c = -c;
			x = (cx * COS_UNIT + r * c) / COS_UNIT;
			dx = x - cx;
			if (dx < 0) dx = -dx;
			dy = (dx >= r) ? 0 : int_sqrt(longint'(r * r) - longint'(dx * dx));
			px.push_back(clamp32(x));
			py.push_back(clamp32(sneg ? cy - dy : cy + dy));
		end
		px.push_back(a.end_x);
		py.push_back(a.end_y);
		n = px.size();
		for (int p = 0; p < n; p += 2) begin
			item.first_x = px[p];
			item.first_y = py[p];
			item.second_valid = (p + 1 < n);
			item.second_x = item.second_valid ? px[p+1] : 32'd0;
			item.second_y = item.second_valid ? py[p+1] : 32'd0;
			item.last_of_arc = (p + 2 >= n);
			pending_points.push_back(item);
		end
	endtask

	// Send one arc; valid stays up until the next idle or the next item.
	task automatic send_arc(arc_t a);
		while (!steady && $urandom_range(99) < 16) begin
			arc_ch.valid <= 1'b0;
			@(posedge clk);
		end
		arc_ch.valid             <= 1'b1;
		arc_ch.center_x          <= a.center_x;
		arc_ch.center_y          <= a.center_y;
		arc_ch.start_x           <= a.start_x;
		arc_ch.start_y           <= a.start_y;
		arc_ch.end_x             <= a.end_x;
		arc_ch.end_y             <= a.end_y;
		arc_ch.radius            <= a.radius;
		arc_ch.counter_clockwise <= a.counter_clockwise;
		do @(posedge clk); while (!arc_ch.ready);
		queue_polyline(a);
		arcs_sent++;
	endtask

	function automatic arc_t make_arc(longint cx, longint cy, longint sx, longint sy,
		longint ex, longint ey, longint r, bit ccw);
		arc_t a;
		a.center_x = cx[31:0]; a.center_y = cy[31:0];
		a.start_x = sx[31:0];  a.start_y = sy[31:0];
		a.end_x = ex[31:0];    a.end_y = ey[31:0];
		a.radius = r[30:0];    a.counter_clockwise = ccw;
		return a;
	endfunction

	// Field extremes, zero radius and coordinates that saturate.
	task automatic test_extremes();
		send_arc(make_arc(0, 0, 100, 0, 0, 100, 0, 1));
		send_arc(make_arc(-2147483648, -2147483648, 2147483647, 2147483647,
			2147483647, -2147483648, 2147483647, 1));
		send_arc(make_arc(2147483647, 2147483647, -2147483648, 2147483647,
			2147483647, -2147483648, 2147483647, 0));
		send_arc(make_arc(0, 0, 1, 1, -1, -1, 2147483647, 1));
		send_arc(make_arc(-1, -1, -2147483648, -2147483648, 2147483647, 0, 1, 0));
	endtask

	// Points on the centre and on the axes, equal angles both ways.
	task automatic test_special_angles();
		send_arc(make_arc(10, 20, 10, 20, 10, 20, 50, 1));   // both at centre
		send_arc(make_arc(10, 20, 10, 20, 60, 20, 50, 0));
		send_arc(make_arc(0, 0, 50, 0, 0, 50, 50, 1));       // 0 to 90
		send_arc(make_arc(0, 0, 0, 50, -50, 0, 50, 1));      // 90 to 180
		send_arc(make_arc(0, 0, -50, 0, 0, -50, 50, 1));     // 180 to 270
		send_arc(make_arc(0, 0, 0, -50, 50, 0, 50, 1));      // 270 to 360
		send_arc(make_arc(0, 0, 50, 0, 0, 50, 50, 0));       // long way round
		send_arc(make_arc(5, 5, 105, 105, 205, 205, 1000, 1)); // equal angles, zero sweep
		send_arc(make_arc(5, 5, 105, 105, 205, 205, 1000, 0)); // equal angles, full turn
		send_arc(make_arc(0, 0, 1000, 1, 1000, -1, 1000, 1));  // near-axis angles
		send_arc(make_arc(0, 0, 1000, 1, 1000, -1, 1000, 0));
		send_arc(make_arc(0, 0, 40, 30, 40, 30, 10, 0));     // dx beyond radius
		send_arc(make_arc(-300, 700, -300, 900, -300, 500, 200, 1));
		send_arc(make_arc(0, 0, 3, 4, -3, -4, 5, 0));
	endtask

	// Random arcs: mostly points near a circle, some fully random fields.
	task automatic test_random(int count);
		arc_t a;
		longint cx, cy, r, span;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) begin
				a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					31'($urandom), 1'($urandom)};
			end else begin
				cx = longint'(signed'($urandom)) >>> $urandom_range(31, 8);
				cy = longint'(signed'($urandom)) >>> $urandom_range(31, 8);
				r = $urandom_range(0, 1 << $urandom_range(1, 24));
				span = r + 2;
				a = make_arc(cx, cy,
					cx + $signed($urandom_range(0, 2 * span)) - span,
					cy + $signed($urandom_range(0, 2 * span)) - span,
					cx + $signed($urandom_range(0, 2 * span)) - span,
					cy + $signed($urandom_range(0, 2 * span)) - span,
					r, $urandom_range(1));
			end
			send_arc(a);
		end
	endtask

	// Check each point item against the oldest expectation.
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && pts_ch.valid && pts_ch.ready) begin
			got = {pts_ch.first_x, pts_ch.first_y, pts_ch.second_x, pts_ch.second_y,
				pts_ch.second_valid, pts_ch.last_of_arc};
			results_seen++;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected points item %h", got);
			end else begin
				want = pending_points.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("points mismatch: expected x0=%0d y0=%0d x1=%0d y1=%0d v=%b l=%b, got x0=%0d y0=%0d x1=%0d y1=%0d v=%b l=%b",
							$signed(want.first_x), $signed(want.first_y),
							$signed(want.second_x), $signed(want.second_y),
							want.second_valid, want.last_of_arc,
							$signed(got.first_x), $signed(got.first_y),
							$signed(got.second_x), $signed(got.second_y),
							got.second_valid, got.last_of_arc);
				end
			end
		end
	end

	// Stall the points channel at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_ch.ready <= 1'b0;
		end else begin
			pts_ch.ready <= steady || ($urandom_range(99) >= 16);
		end
	end

	// Count cycles with no item moving either way.
	always @(posedge clk) begin
		if (!arst_n || (arc_ch.valid && arc_ch.ready) || (pts_ch.valid && pts_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !wrapped_up) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("arc_to_polyline_tessellator_unit verification failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		arcs_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		steady = 0;
		wrapped_up = 0;
		arst_n = 1'b0;
		arc_ch.valid = 1'b0;
		arc_ch.center_x = '0;
		arc_ch.center_y = '0;
		arc_ch.start_x = '0;
		arc_ch.start_y = '0;
		arc_ch.end_x = '0;
		arc_ch.end_y = '0;
		arc_ch.radius = '0;
		arc_ch.counter_clockwise = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_special_angles();
		test_random(60);
		steady = 1;               // a stretch with no idling on either side
		test_random(30);
		steady = 0;
		test_random(60);
		arc_ch.valid <= 1'b0;

		while (pending_points.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		wrapped_up = 1;

		$display("covered %0d arcs (axes, centre points, equal angles, full turns, saturation)",
			arcs_sent);
		$display("checked %0d point items, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && pending_points.size() == 0)
			$display("arc_to_polyline_tessellator_unit verification clean");
		else
			$display("arc_to_polyline_tessellator_unit verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/atp_pkg.sv
src/atp_arc_if.sv
src/atp_pts_if.sv
src/atp_cordic.sv
src/atp_isqrt.sv
src/atp_dp.sv
src/atp_ctrl.sv
src/arc_to_polyline_tessellator_unit.sv
src/atp_checker.sv
sim/testbench.sv
